FILE: design/lfr_pkg.sv
// Package for the LIN frame responder: constants, codes, result type and CRC function.
`timescale 1ns / 1ps
package lfr_pkg;

	localparam int BUFFER_BYTES = 16;
	localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
	localparam int HEADER_LEN   = 4;
	localparam int KEPT_BYTES   = 5;
	localparam int KEPT_IDX_W   = $clog2(KEPT_BYTES);

	localparam logic [7:0] SYNC_BRK  = 8'h00;
	localparam logic [7:0] SYNC_DEL  = 8'h80;
	localparam logic [7:0] SYNC_BYTE = 8'h55;
	localparam logic [7:0] CRC_POLY  = 8'h8C;

	// result queue
	localparam int RESQ_DEPTH = 4;
	localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
	localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

	// config register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_REPLY_VALUE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_READ_ID     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_ID    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STATUS_ID   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAN_MASK    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIN_MASK    = 3'd5;

	// input op codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_IDLE = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_REPLY  = 2'd0;
	localparam logic [1:0] KIND_TEMP   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       can_up;
		logic       lin_up;
		logic       last;
	} res_t;

	// reflected CRC-8, init 0, LSB first
	function automatic logic [7:0] crc8_refl(input logic [7:0] data);
		logic [7:0] crc;
		logic [7:0] d;
		crc = '0;
		d   = data;
		for (int b = 0; b < 8; b++) begin
			if ((crc[0] ^ d[0]) == 1'b1) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
			d = d >> 1;
		end
		return crc;
	endfunction

endpackage

FILE: design/lin_frame_responder.sv
// LIN frame responder: collects bus bytes, decodes frames on line idle, queues results.
//
// One item (a received byte or a line-idle event) is taken per clock. The item is
// registered, decoded in one pass against the frame buffer and the config registers,
// and its results (none, one, or two for a read request: reply byte then its CRC-8)
// go into a four-entry result queue that drains one result per clock. The input side
// stalls only while an item waits in the input register and the queue has fewer than
// two free entries, so throughput is one item per cycle unless the result side backs up.
// Configuration is written through a separate always-ready port, one register per cycle.
`timescale 1ns / 1ps
module lin_frame_responder (
	input  logic                          clk,
	input  logic                          arst_n,
	// config
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	// input items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [7:0]                    rx_byte,
	// results
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    kind,
	output logic [7:0]                    value,
	output logic                          can_up,
	output logic                          lin_up,
	output logic                          last
);
	import lfr_pkg::*;

	// config registers
	logic [7:0] reply_value_q, read_id_q, write_id_q, status_id_q, can_mask_q, lin_mask_q;

	// frame state
	logic [7:0]       frame_q [KEPT_BYTES];
	logic [7:0]       frame_d [KEPT_BYTES];
	logic [CNT_W-1:0] byte_cnt_q, byte_cnt_d;
	logic             hdr_q, hdr_d;
	logic             can_q, can_d, lin_q, lin_d;

	// input register
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] rx_s1;
	logic       fire_s1;

	// result queue
	res_t                  resq_q [RESQ_DEPTH];
	logic [RESQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [RESQ_CNT_W-1:0] resq_cnt_q;
	logic [1:0]            n_push;
	res_t                  res0, res1;
	logic                  pop;
	res_t                  head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_value_q <= 8'd0;
			read_id_q     <= 8'd77;
			write_id_q    <= 8'd7;
			status_id_q   <= 8'd55;
			can_mask_q    <= 8'd1;
			lin_mask_q    <= 8'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REPLY_VALUE: reply_value_q <= cfg_data;
				REG_READ_ID:     read_id_q     <= cfg_data;
				REG_WRITE_ID:    write_id_q    <= cfg_data;
				REG_STATUS_ID:   status_id_q   <= cfg_data;
				REG_CAN_MASK:    can_mask_q    <= cfg_data;
				REG_LIN_MASK:    lin_mask_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// room for the worst case of two results
	assign fire_s1  = valid_s1 && (resq_cnt_q <= RESQ_CNT_W'(RESQ_DEPTH - 2));
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= op;
			rx_s1 <= rx_byte;
		end
	end

	always_comb begin
		logic [7:0] id;
		logic [7:0] data;
		frame_d    = frame_q;
		byte_cnt_d = byte_cnt_q;
		hdr_d      = hdr_q;
		can_d      = can_q;
		lin_d      = lin_q;
		n_push     = 2'd0;
		res0       = '0;
		res1       = '0;
		id         = frame_q[3];
		data       = frame_q[4];
		if (fire_s1) begin
			if (op_s1 == OP_BYTE) begin
				if (byte_cnt_q < CNT_W'(KEPT_BYTES)) begin
					frame_d[byte_cnt_q[KEPT_IDX_W-1:0]] = rx_s1;
				end
				if (byte_cnt_q < CNT_W'(BUFFER_BYTES)) begin
					byte_cnt_d = byte_cnt_q + CNT_W'(1);
				end
				if (byte_cnt_d == CNT_W'(HEADER_LEN) && frame_d[0] == SYNC_BRK &&
				    frame_d[1] == SYNC_DEL && frame_d[2] == SYNC_BYTE) begin
					hdr_d = 1'b1;
				end
			end else if (hdr_q) begin
				if (byte_cnt_q == CNT_W'(HEADER_LEN)) begin
					if (id == read_id_q) begin
						res0   = '{kind: KIND_REPLY, value: reply_value_q, can_up: can_q,
						           lin_up: lin_q, last: 1'b0};
						res1   = '{kind: KIND_REPLY, value: crc8_refl(reply_value_q),
						           can_up: can_q, lin_up: lin_q, last: 1'b1};
						n_push = 2'd2;
					end
				end else if (byte_cnt_q > CNT_W'(HEADER_LEN) &&
				             byte_cnt_q < CNT_W'(BUFFER_BYTES)) begin
					if (id == write_id_q) begin
						res0   = '{kind: KIND_TEMP, value: data, can_up: can_q,
						           lin_up: lin_q, last: 1'b1};
						n_push = 2'd1;
					end else if (id == status_id_q) begin
						can_d  = |(data & can_mask_q);
						lin_d  = |(data & lin_mask_q);
						res0   = '{kind: KIND_STATUS, value: 8'd0, can_up: can_d,
						           lin_up: lin_d, last: 1'b1};
						n_push = 2'd1;
					end
				end
				// every decoded frame is dropped
				hdr_d      = 1'b0;
				byte_cnt_d = '0;
				for (int i = 0; i < KEPT_BYTES; i++) begin
					frame_d[i] = 8'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEPT_BYTES; i++) begin
				frame_q[i] <= 8'd0;
			end
			byte_cnt_q <= '0;
			hdr_q      <= 1'b0;
			can_q      <= 1'b0;
			lin_q      <= 1'b0;
		end else begin
			frame_q    <= frame_d;
			byte_cnt_q <= byte_cnt_d;
			hdr_q      <= hdr_d;
			can_q      <= can_d;
			lin_q      <= lin_d;
		end
	end

	// result queue
	assign head      = resq_q[rd_ptr_q];
	assign out_valid = (resq_cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign kind      = head.kind;
	assign value     = head.value;
	assign can_up    = head.can_up;
	assign lin_up    = head.lin_up;
	assign last      = head.last;

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			resq_q[wr_ptr_q] <= res0;
		end
		if (n_push == 2'd2) begin
			resq_q[wr_ptr_q + RESQ_PTR_W'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			resq_cnt_q <= '0;
		end else begin
			wr_ptr_q   <= wr_ptr_q + RESQ_PTR_W'(n_push);
			rd_ptr_q   <= rd_ptr_q + RESQ_PTR_W'(pop);
			resq_cnt_q <= resq_cnt_q + RESQ_CNT_W'(n_push) - RESQ_CNT_W'(pop);
		end
	end

	// checks
	a_resq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		resq_cnt_q <= RESQ_CNT_W'(RESQ_DEPTH))
		else $error("result queue overflow");

	a_hdr_len: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_q |-> (byte_cnt_q >= CNT_W'(HEADER_LEN)))
		else $error("header marked on a short frame");

	a_idle_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && op_s1 == OP_IDLE && hdr_q) |=> (byte_cnt_q == '0 && !hdr_q))
		else $error("decoded frame not cleared");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && resq_cnt_q > RESQ_CNT_W'(RESQ_DEPTH - 2)))
		else $error("input stalled without cause");

endmodule

FILE: tb/lfr_checker.sv
// Checker for the LIN frame responder: tracks frame state, predicts results, compares outputs.
`timescale 1ns / 1ps
module lfr_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [lfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          op,
	input  logic [7:0]                    rx_byte,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [1:0]                    kind,
	input  logic [7:0]                    value,
	input  logic                          can_up,
	input  logic                          lin_up,
	input  logic                          last,
	output int                            fail_count,
	output int                            results_due
);
	import lfr_pkg::*;

	// shadow copies of the config registers
	logic [7:0] reply_byte_r, read_id_r, write_id_r, status_id_r, can_mask_r, lin_mask_r;

	// shadow frame state
	logic [7:0]       kept_bytes [KEPT_BYTES];
	logic [CNT_W-1:0] byte_tally;
	logic             hdr_ok;
	logic [7:0]       temp_r;
	logic             can_r, lin_r;

	res_t frame_results_q [$];

	function automatic logic [7:0] crc8_lsb_first(input logic [7:0] d);
		logic [7:0] c;
		logic       fb;
		c = 8'h00;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ d[i];
			c  = {1'b0, c[7:1]} ^ ({8{fb}} & CRC_POLY);
		end
		return c;
	endfunction

	function automatic res_t pack_result(input logic [1:0] k, input logic [7:0] v,
			input logic is_last);
		res_t r;
		r.kind   = k;
		r.value  = v;
		r.can_up = can_r;
		r.lin_up = lin_r;
		r.last   = is_last;
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
			fail_count++;
		end
	endfunction

	task automatic track_bus_item(input logic item_op, input logic [7:0] item_byte);
		logic [7:0] id;
		logic [7:0] data;
		if (item_op == OP_BYTE) begin
			if (byte_tally < KEPT_BYTES) kept_bytes[byte_tally[KEPT_IDX_W-1:0]] = item_byte;
			if (byte_tally < BUFFER_BYTES) byte_tally++;
			if (byte_tally == HEADER_LEN && kept_bytes[0] == SYNC_BRK &&
					kept_bytes[1] == SYNC_DEL && kept_bytes[2] == SYNC_BYTE) begin
				hdr_ok = 1'b1;
			end
		end else if (hdr_ok) begin
			id   = kept_bytes[3];
			data = kept_bytes[4];
			if (byte_tally == HEADER_LEN) begin
				if (id == read_id_r) begin
					frame_results_q.push_back(pack_result(KIND_REPLY, reply_byte_r, 1'b0));
					frame_results_q.push_back(pack_result(KIND_REPLY,
						crc8_lsb_first(reply_byte_r), 1'b1));
				end
			end else if (byte_tally > HEADER_LEN && byte_tally < BUFFER_BYTES) begin
				if (id == write_id_r) begin
					temp_r = data;
					frame_results_q.push_back(pack_result(KIND_TEMP, temp_r, 1'b1));
				end else if (id == status_id_r) begin
					can_r = |(data & can_mask_r);
					lin_r = |(data & lin_mask_r);
					frame_results_q.push_back(pack_result(KIND_STATUS, 8'h00, 1'b1));
				end
			end
			// any frame that had a header is dropped on idle
			hdr_ok     = 1'b0;
			byte_tally = '0;
			for (int i = 0; i < KEPT_BYTES; i++) kept_bytes[i] = 8'h00;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			reply_byte_r = 8'd0;
			read_id_r    = 8'd77;
			write_id_r   = 8'd7;
			status_id_r  = 8'd55;
			can_mask_r   = 8'd1;
			lin_mask_r   = 8'd2;
			for (int i = 0; i < KEPT_BYTES; i++) kept_bytes[i] = 8'h00;
			byte_tally   = '0;
			hdr_ok       = 1'b0;
			temp_r       = 8'h00;
			can_r        = 1'b0;
			lin_r        = 1'b0;
			frame_results_q.delete();
			fail_count   = 0;
			results_due  = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (frame_results_q.size() == 0) begin
					$display("%0t ns: result with none expected, expected nothing, got kind %0h value %0h",
						$time, kind, value);
					fail_count++;
				end else begin
					want = frame_results_q.pop_front();
					check_field("kind", 8'(want.kind), 8'(kind));
					check_field("value", want.value, value);
					check_field("can_up", 8'(want.can_up), 8'(can_up));
					check_field("lin_up", 8'(want.lin_up), 8'(lin_up));
					check_field("last", 8'(want.last), 8'(last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_REPLY_VALUE: reply_byte_r = cfg_data;
					REG_READ_ID:     read_id_r    = cfg_data;
					REG_WRITE_ID:    write_id_r   = cfg_data;
					REG_STATUS_ID:   status_id_r  = cfg_data;
					REG_CAN_MASK:    can_mask_r   = cfg_data;
					REG_LIN_MASK:    lin_mask_r   = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) track_bus_item(op, rx_byte);
			results_due = frame_results_q.size();
		end
	end

endmodule

FILE: tb/tb_lin_frame_responder.sv
// Testbench top for the LIN frame responder: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_lin_frame_responder;
	import lfr_pkg::*;

	localparam int HALF_PERIOD      = 6;
	localparam int RESET_CYCLES     = 9;
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int SETTLE_CYCLES    = 8;
	localparam int HOLD_CYCLES      = 300;
	localparam int PHASES           = 8;
	localparam int FRAMES_PER_PHASE = 25;
	localparam int GAP_PERCENT      = 11;

	logic                 clk    = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	logic                 in_valid, in_ready;
	logic                 op;
	logic [7:0]           rx_byte;
	logic                 out_valid, out_ready;
	logic [1:0]           kind;
	logic [7:0]           value;
	logic                 can_up, lin_up, last;

	int fail_count;
	int results_due;
	int idle_cycles;

	bit tx_gaps  = 1'b1;
	bit rx_gaps  = 1'b1;
	bit hold_req = 1'b0;

	// ids currently programmed, used to aim frames at real matches
	logic [7:0] cur_read_id   = 8'd77;
	logic [7:0] cur_write_id  = 8'd7;
	logic [7:0] cur_status_id = 8'd55;

	always #HALF_PERIOD clk = ~clk;

	lin_frame_responder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.value     (value),
		.can_up    (can_up),
		.lin_up    (lin_up),
		.last      (last)
	);

	lfr_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.value       (value),
		.can_up      (can_up),
		.lin_up      (lin_up),
		.last        (last),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	// result side: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// entered and left at a falling edge; valid stays up between back-to-back items
	task automatic send_item(input logic item_op, input logic [7:0] item_byte);
		while (tx_gaps && $urandom_range(0, 99) < GAP_PERCENT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= item_op;
		rx_byte  <= item_byte;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (results_due != 0) @(negedge clk);
		// an idle item with no result may still be in flight
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic send_frame(input logic [7:0] id, input int n_data,
			input logic [7:0] first_data, input bit stray_idle);
		send_item(OP_BYTE, SYNC_BRK);
		send_item(OP_BYTE, SYNC_DEL);
		// idle before the header is complete is ignored
		if (stray_idle) send_item(OP_IDLE, 8'($urandom));
		send_item(OP_BYTE, SYNC_BYTE);
		send_item(OP_BYTE, id);
		for (int i = 0; i < n_data; i++)
			send_item(OP_BYTE, (i == 0) ? first_data : 8'($urandom));
		send_item(OP_IDLE, 8'($urandom));
	endtask

	task automatic random_frame();
		int         pick;
		int         n_data;
		logic [7:0] id;
		pick   = $urandom_range(0, 99);
		n_data = 0;
		if (pick < 30) begin
			id = cur_read_id;
			if ($urandom_range(0, 4) == 0) n_data = $urandom_range(1, 3);
		end else begin
			if (pick < 55) id = cur_write_id;
			else if (pick < 80) id = cur_status_id;
			else id = 8'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 15) n_data = 0;
			else if (pick < 80) n_data = $urandom_range(1, 4);
			else if (pick < 94) n_data = $urandom_range(5, BUFFER_BYTES - HEADER_LEN - 1);
			else n_data = $urandom_range(BUFFER_BYTES - HEADER_LEN, BUFFER_BYTES + 2);
		end
		if ($urandom_range(0, 9) == 0) send_item(OP_IDLE, 8'($urandom));
		send_frame(id, n_data, 8'($urandom), $urandom_range(0, 9) == 0);
	endtask

	task automatic load_config(input logic [7:0] rv, input logic [7:0] rid,
			input logic [7:0] wid, input logic [7:0] sid,
			input logic [7:0] cm, input logic [7:0] lm);
		logic [CFG_IDX_W-1:0] idx  [6];
		logic [7:0]           vals [6];
		idx  = '{REG_REPLY_VALUE, REG_READ_ID, REG_WRITE_ID, REG_STATUS_ID,
			REG_CAN_MASK, REG_LIN_MASK};
		vals = '{rv, rid, wid, sid, cm, lm};
		drain_results();
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			@(negedge clk);
		end
		cfg_valid     <= 1'b0;
		cur_read_id   = rid;
		cur_write_id  = wid;
		cur_status_id = sid;
	endtask

	initial begin
		in_valid  = 1'b0;
		op        = OP_BYTE;
		rx_byte   = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = REG_REPLY_VALUE;
		cfg_data  = 8'h00;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset config: read, write, status, unknown id
		send_item(OP_IDLE, 8'hFF);
		send_frame(cur_read_id, 0, 8'h00, 1'b0);
		send_frame(cur_write_id, 1, 8'hFF, 1'b0);
		send_frame(cur_status_id, 1, 8'hFF, 1'b0);
		send_frame(8'h00, 0, 8'h00, 1'b0);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: ;
				1: load_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
				2: load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
				default: load_config(8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			tx_gaps = (ph != 3);
			rx_gaps = (ph != 3);
			if (ph == 5) begin
				// results back up while read requests keep coming
				hold_req = 1'b1;
				tx_gaps  = 1'b0;
				for (int i = 0; i < 6; i++) send_frame(cur_read_id, 0, 8'h00, 1'b0);
				drain_results();
				tx_gaps = 1'b1;
			end
			repeat (FRAMES_PER_PHASE) random_frame();
		end

		// a broken sync byte leaves the buffer without a header for good
		send_item(OP_BYTE, SYNC_BRK);
		send_item(OP_BYTE, SYNC_DEL);
		send_item(OP_BYTE, ~SYNC_BYTE);
		send_item(OP_BYTE, cur_read_id);
		send_item(OP_IDLE, 8'($urandom));
		repeat (24) send_item(($urandom_range(0, 3) == 0) ? OP_IDLE : OP_BYTE, 8'($urandom));

		drain_results();
		repeat (20) @(negedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
